// ===== rtl/mdt_pkg.sv =====
// mdt_pkg: shared types and constants of the duty tracker.
// Used by the front, queue, back, top level and checker. No dependencies.
package mdt_pkg;

   localparam int VOLT_W  = 16;
   localparam int CURR_W  = 16;
   localparam int POWER_W = 32;
   localparam int DUTY_W  = 17;
   localparam int SLOPE_W = 24;
   localparam int STEP_W  = 16;

   localparam logic [DUTY_W-1:0]  DUTY_ONE   = 17'd65536;
   localparam logic [DUTY_W-1:0]  DUTY_RESET = 17'd24052;
   localparam logic [SLOPE_W-1:0] SLOPE_MAX  = 24'hFFFFFF;

   // register indexes
   localparam logic [2:0] REG_LARGE_STEP   = 3'd0;
   localparam logic [2:0] REG_SMALL_STEP   = 3'd1;
   localparam logic [2:0] REG_CURRENT_GAIN = 3'd2;
   localparam logic [2:0] REG_SLOPE_LOW    = 3'd3;
   localparam logic [2:0] REG_SLOPE_HIGH   = 3'd4;
   localparam logic [2:0] REG_VAR_STEP_OFF = 3'd5;

   localparam logic [STEP_W-1:0]  LARGE_STEP_RST   = 16'd655;
   localparam logic [STEP_W-1:0]  SMALL_STEP_RST   = 16'd7;
   localparam logic [STEP_W-1:0]  CURRENT_GAIN_RST = 16'd66;
   localparam logic [SLOPE_W-1:0] SLOPE_LOW_RST    = 24'd512;
   localparam logic [SLOPE_W-1:0] SLOPE_HIGH_RST   = 24'd5120;

   typedef struct packed {
      logic [STEP_W-1:0]  large_step;
      logic [STEP_W-1:0]  small_step;
      logic [STEP_W-1:0]  current_gain;
      logic [SLOPE_W-1:0] slope_low;
      logic [SLOPE_W-1:0] slope_high;
      logic               variable_step_off;
   } cfg_type;

   // one classified sample, front to back
   typedef struct packed {
      logic               v_changed;
      logic               dv_neg;
      logic [VOLT_W-1:0]  dv_abs;
      logic               dp_neg;
      logic               dp_zero;
      logic [POWER_W-1:0] dp_abs;
      logic               di_neg;
      logic [CURR_W-1:0]  di_abs;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ===== rtl/mdt_front.sv =====
// mdt_front: accepts samples, forms power and the differences to the previous sample.
// Depends on mdt_pkg; feeds mdt_queue.
module mdt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mdt_pkg::VOLT_W-1:0]    req_panel_voltage,
   input  logic [mdt_pkg::CURR_W-1:0]    req_panel_current,
   input  mdt_pkg::qstat_type            qstat,
   output logic                          push,
   output mdt_pkg::work_type             push_data
);

   logic                          hold_valid_ff, hold_valid_in;
   logic [mdt_pkg::VOLT_W-1:0]    volt_ff, volt_in;
   logic [mdt_pkg::CURR_W-1:0]    curr_ff, curr_in;
   logic [mdt_pkg::POWER_W-1:0]   power_ff, power_in;
   logic [mdt_pkg::VOLT_W-1:0]    prev_volt_ff, prev_volt_in;
   logic [mdt_pkg::CURR_W-1:0]    prev_curr_ff, prev_curr_in;
   logic [mdt_pkg::POWER_W-1:0]   prev_power_ff, prev_power_in;
   logic                          accept;

   assign req_stall = hold_valid_ff && qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = hold_valid_ff && !qstat.full;

   always_comb begin
      push_data.v_changed = (volt_ff != prev_volt_ff);
      push_data.dv_neg    = (volt_ff < prev_volt_ff);
      push_data.dv_abs    = push_data.dv_neg ? (prev_volt_ff - volt_ff)
                                             : (volt_ff - prev_volt_ff);
      push_data.dp_neg    = (power_ff < prev_power_ff);
      push_data.dp_zero   = (power_ff == prev_power_ff);
      push_data.dp_abs    = push_data.dp_neg ? (prev_power_ff - power_ff)
                                             : (power_ff - prev_power_ff);
      push_data.di_neg    = (curr_ff < prev_curr_ff);
      push_data.di_abs    = push_data.di_neg ? (prev_curr_ff - curr_ff)
                                             : (curr_ff - prev_curr_ff);
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      volt_in       = volt_ff;
      curr_in       = curr_ff;
      power_in      = power_ff;
      prev_volt_in  = prev_volt_ff;
      prev_curr_in  = prev_curr_ff;
      prev_power_in = prev_power_ff;
      if (push) begin
         hold_valid_in = 1'b0;
         prev_volt_in  = volt_ff;
         prev_curr_in  = curr_ff;
         prev_power_in = power_ff;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         volt_in       = req_panel_voltage;
         curr_in       = req_panel_current;
         power_in      = req_panel_voltage * req_panel_current;
      end
   end

   always_ff @(posedge clock) begin
      volt_ff  <= volt_in;
      curr_ff  <= curr_in;
      power_ff <= power_in;
      if (reset) begin
         hold_valid_ff <= 1'b0;
         prev_volt_ff  <= '0;
         prev_curr_ff  <= '0;
         prev_power_ff <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         prev_volt_ff  <= prev_volt_in;
         prev_curr_ff  <= prev_curr_in;
         prev_power_ff <= prev_power_in;
      end
   end

endmodule

// ===== rtl/mdt_queue.sv =====
// mdt_queue: small register FIFO of classified samples between front and back.
// Depends on mdt_pkg.
module mdt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mdt_pkg::work_type   push_data,
   input  logic                pop,
   output mdt_pkg::work_type   pop_data,
   output mdt_pkg::qstat_type  qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mdt_pkg::work_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == FULL_CNT);
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/mdt_back.sv =====
// mdt_back: serial slope divider, current-gain multiply and duty update with output register.
// Depends on mdt_pkg; pops mdt_queue.
module mdt_back (
   input  logic                           clock,
   input  logic                           reset,
   input  mdt_pkg::cfg_type               cfg,
   input  mdt_pkg::qstat_type             qstat,
   input  mdt_pkg::work_type              pop_data,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mdt_pkg::DUTY_W-1:0]     rsp_duty,
   output logic                           rsp_voltage_changed,
   output logic                           rsp_at_peak,
   output logic [mdt_pkg::SLOPE_W-1:0]    rsp_slope_magnitude
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_DONE} state_type;

   localparam int SUM_W = 26;

   state_type                        state_ff, state_in;
   mdt_pkg::work_type                item_ff, item_in;
   logic [mdt_pkg::VOLT_W-1:0]       rem_ff, rem_in;
   logic [mdt_pkg::POWER_W-1:0]      quo_ff, quo_in;
   logic [4:0]                       cnt_ff, cnt_in;
   logic [31:0]                      prod_ff, prod_in;
   logic [mdt_pkg::DUTY_W-1:0]       prev_duty_ff, prev_duty_in;
   logic [mdt_pkg::SLOPE_W-1:0]      last_slope_ff, last_slope_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mdt_pkg::DUTY_W-1:0]       duty_ff, duty_in;
   logic                             vchg_ff, vchg_in;
   logic                             peak_ff, peak_in;
   logic [mdt_pkg::SLOPE_W-1:0]      slope_ff, slope_in;

   logic [17:0]                      diff;
   logic [mdt_pkg::SLOPE_W-1:0]      mag;
   logic                             window;
   logic [mdt_pkg::STEP_W-1:0]       step;
   logic [23:0]                      delta_mag;
   logic                             delta_neg;
   logic [SUM_W-1:0]                 base;
   logic [SUM_W-1:0]                 sum;
   logic [mdt_pkg::DUTY_W-1:0]       new_duty;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_duty            = duty_ff;
   assign rsp_voltage_changed = vchg_ff;
   assign rsp_at_peak         = peak_ff;
   assign rsp_slope_magnitude = slope_ff;

   // restoring division step and duty arithmetic
   always_comb begin
      diff   = {1'b0, rem_ff, quo_ff[31]} - {2'b00, item_ff.dv_abs};
      mag    = (quo_ff[31:24] != '0) ? mdt_pkg::SLOPE_MAX : quo_ff[23:0];
      window = (mag > cfg.slope_low) && (mag < cfg.slope_high) && !cfg.variable_step_off;
      step   = window ? cfg.large_step : cfg.small_step;
      if (item_ff.v_changed) begin
         delta_mag = item_ff.dp_zero ? '0 : {8'd0, step};
         // rising power with rising voltage lowers the duty
         delta_neg = (item_ff.dp_neg == item_ff.dv_neg);
      end else begin
         delta_mag = prod_ff[31:8];
         delta_neg = item_ff.di_neg;
      end
      base = {{(SUM_W - mdt_pkg::DUTY_W){1'b0}}, prev_duty_ff};
      sum  = delta_neg ? base - {2'b00, delta_mag} : base + {2'b00, delta_mag};
      if (sum[SUM_W-1]) begin
         new_duty = '0;
      end else if (sum > {{(SUM_W - mdt_pkg::DUTY_W){1'b0}}, mdt_pkg::DUTY_ONE}) begin
         new_duty = mdt_pkg::DUTY_ONE;
      end else begin
         new_duty = sum[mdt_pkg::DUTY_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      prev_duty_in  = prev_duty_ff;
      last_slope_in = last_slope_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      duty_in       = duty_ff;
      vchg_in       = vchg_ff;
      peak_in       = peak_ff;
      slope_in      = slope_ff;
      pop           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               item_in  = pop_data;
               rem_in   = '0;
               quo_in   = pop_data.dp_abs;
               cnt_in   = '0;
               state_in = pop_data.v_changed ? ST_DIV : ST_MUL;
            end
         end
         ST_DIV: begin
            if (!diff[17]) begin
               rem_in = diff[15:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[14:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            prod_in  = item_ff.di_abs * cfg.current_gain;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               duty_in      = new_duty;
               prev_duty_in = new_duty;
               vchg_in      = item_ff.v_changed;
               peak_in      = !item_ff.v_changed || item_ff.dp_zero;
               if (item_ff.v_changed) begin
                  last_slope_in = mag;
                  slope_in      = mag;
               end else begin
                  slope_in      = last_slope_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      duty_ff  <= duty_in;
      vchg_ff  <= vchg_in;
      peak_ff  <= peak_in;
      slope_ff <= slope_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_duty_ff  <= mdt_pkg::DUTY_RESET;
         last_slope_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_duty_ff  <= prev_duty_in;
         last_slope_ff <= last_slope_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/mppt_duty_tracker.sv =====
// mppt_duty_tracker: top level of the hill-climbing duty tracker, with its register file.
// Depends on mdt_pkg, mdt_front, mdt_queue and mdt_back.
//
//   channel   ports       handshake                 moves
//   input     req_*       req_valid / req_stall     one voltage and current sample a beat
//   result    rsp_*       rsp_valid / rsp_stall     one duty, flags and slope a beat
//   config    APB         psel/penable/pwrite       one register write a beat
//
// The back end passes a sample whose voltage changed through the one-bit-a-cycle slope
// divider, and a sample whose voltage held through the gain multiply, one sample at a time.
// The front takes a sample every cycle until the queue and its holding register are full, so bursts are absorbed.
// Synchronous active-high reset; no clearing pass, the block is ready right after reset.
// A stalled result holds in the output register while the next sample is already computed.
module mppt_duty_tracker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mdt_pkg::VOLT_W-1:0]     req_panel_voltage,
   input  logic [mdt_pkg::CURR_W-1:0]     req_panel_current,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mdt_pkg::DUTY_W-1:0]     rsp_duty,
   output logic                           rsp_voltage_changed,
   output logic                           rsp_at_peak,
   output logic [mdt_pkg::SLOPE_W-1:0]    rsp_slope_magnitude,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [4:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   mdt_pkg::cfg_type     cfg_ff, cfg_in;
   mdt_pkg::qstat_type   qstat;
   mdt_pkg::work_type    push_data;
   mdt_pkg::work_type    pop_data;
   logic                 push;
   logic                 pop;
   logic                 wr_en;
   logic [2:0]           reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mdt_pkg::REG_LARGE_STEP:   cfg_in.large_step        = pwdata[15:0];
            mdt_pkg::REG_SMALL_STEP:   cfg_in.small_step        = pwdata[15:0];
            mdt_pkg::REG_CURRENT_GAIN: cfg_in.current_gain      = pwdata[15:0];
            mdt_pkg::REG_SLOPE_LOW:    cfg_in.slope_low         = pwdata[23:0];
            mdt_pkg::REG_SLOPE_HIGH:   cfg_in.slope_high        = pwdata[23:0];
            mdt_pkg::REG_VAR_STEP_OFF: cfg_in.variable_step_off = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mdt_pkg::REG_LARGE_STEP:   prdata = {16'd0, cfg_ff.large_step};
         mdt_pkg::REG_SMALL_STEP:   prdata = {16'd0, cfg_ff.small_step};
         mdt_pkg::REG_CURRENT_GAIN: prdata = {16'd0, cfg_ff.current_gain};
         mdt_pkg::REG_SLOPE_LOW:    prdata = {8'd0, cfg_ff.slope_low};
         mdt_pkg::REG_SLOPE_HIGH:   prdata = {8'd0, cfg_ff.slope_high};
         mdt_pkg::REG_VAR_STEP_OFF: prdata = {31'd0, cfg_ff.variable_step_off};
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.large_step        <= mdt_pkg::LARGE_STEP_RST;
         cfg_ff.small_step        <= mdt_pkg::SMALL_STEP_RST;
         cfg_ff.current_gain      <= mdt_pkg::CURRENT_GAIN_RST;
         cfg_ff.slope_low         <= mdt_pkg::SLOPE_LOW_RST;
         cfg_ff.slope_high        <= mdt_pkg::SLOPE_HIGH_RST;
         cfg_ff.variable_step_off <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mdt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_panel_voltage (req_panel_voltage),
      .req_panel_current (req_panel_current),
      .qstat             (qstat),
      .push              (push),
      .push_data         (push_data)
   );

   mdt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   mdt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .qstat               (qstat),
      .pop_data            (pop_data),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty            (rsp_duty),
      .rsp_voltage_changed (rsp_voltage_changed),
      .rsp_at_peak         (rsp_at_peak),
      .rsp_slope_magnitude (rsp_slope_magnitude)
   );

endmodule

// ===== rtl/mdt_checker.sv =====
// mdt_checker: port-level assertions for mppt_duty_tracker, bound to the top level.
// Depends on mdt_pkg and the top level's ports.
module mdt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [mdt_pkg::DUTY_W-1:0]     rsp_duty,
   input  logic                           rsp_voltage_changed,
   input  logic                           rsp_at_peak
);

   // no result can be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty))
      else $error("stalled result changed");

   // duty saturates to 1.0
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= mdt_pkg::DUTY_ONE)
      else $error("duty above full scale");

   // the current branch always reports the peak flag
   a_peak_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_voltage_changed |-> rsp_at_peak)
      else $error("peak flag low with voltage unchanged");

endmodule

bind mppt_duty_tracker mdt_checker u_checker (.*);
